[rtl/text_console_writer_top_defines.svh]
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

`ifndef SYNTH
`define TCW_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console writer: implication check failed");
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");
`else
`define TCW_ASSERT_IMPLIES(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int READ_ROW_W   = 5;
   localparam int READ_COL_W   = 7;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 5;
   localparam int CELL_W       = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] RESET_ATTR   = 8'd7;
   localparam logic [6:0] RESET_TAB    = 7'd4;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;
   localparam logic [0:0] REG_TAB_ADVANCE    = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [7:0]            char_code;
      logic [READ_ROW_W-1:0] read_row;
      logic [READ_COL_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]              cell_char;
      logic [7:0]              cell_attr;
      logic [CURSOR_COL_W-1:0] cursor_col;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic                    did_scroll;
   } rsp_type;

   typedef struct packed {
      logic [7:0] text_attribute;
      logic [6:0] tab_advance;
   } cfg_type;

endpackage

[rtl/tcw_stream_if.sv]
// Valid/ready channel carrying one payload per transaction.
interface tcw_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/tcw_csr.sv]
// APB register block holding the attribute and tab settings.
module tcw_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output tcw_pkg::cfg_type               cfg
);
   import tcw_pkg::*;

   logic [7:0] attr_ff;
   logic [7:0] attr_in;
   logic [6:0] tab_ff;
   logic [6:0] tab_in;
   logic       wr_en;
   logic [0:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2:2];

   always_comb begin
      attr_in = attr_ff;
      tab_in  = tab_ff;
      prdata  = '0;
      unique case (reg_sel)
         REG_TEXT_ATTRIBUTE: begin
            prdata = CSR_DATA_W'(attr_ff);
            if (wr_en) begin
               attr_in = pwdata[7:0];
            end
         end
         REG_TAB_ADVANCE: begin
            prdata = CSR_DATA_W'(tab_ff);
            if (wr_en) begin
               tab_in = pwdata[6:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
         tab_ff  <= RESET_TAB;
      end else begin
         attr_ff <= attr_in;
         tab_ff  <= tab_in;
      end
   end

   assign cfg.text_attribute = attr_ff;
   assign cfg.tab_advance    = tab_ff;
endmodule

[rtl/text_console_writer_top.sv]
// Text console writer: cursor sequencer around one cell RAM with a rotating top row.
// A read passes the address and read states, a put the handle state, then the result is
// registered; a tab adds one divide step plus one per row crossed, each scroll (two at
// most) a pass over one row. One transaction at a time: the next is taken once the sequencer
// is idle and the result slot is empty or being taken. Reset: a clearing pass fills the RAM
// with spaces of attribute 7; no request is taken meanwhile, register writes are.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   tcw_stream_if.sink                     req_ch,
   tcw_stream_if.source                   rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import tcw_pkg::*;

   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int SADDR_W = ADDR_W + 1;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS + 1);
   localparam int SUM_W   = $clog2(COLUMNS + 128);
   localparam int MROW_W  = (ROW_W > READ_ROW_W) ? ROW_W : READ_ROW_W;
   localparam int PROD_W  = MROW_W + $clog2(COLUMNS + 1);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_RADDR  = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_HANDLE = 3'd4;
   localparam logic [2:0] ST_TABDIV = 3'd5;
   localparam logic [2:0] ST_SCROLL = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   cfg_type cfg;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            after_ff, after_in;
   logic [COL_W-1:0]      cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic                  scrolled_ff, scrolled_in;
   logic [7:0]            code_ff, code_in;
   logic [READ_COL_W-1:0] rcol_ff, rcol_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [ADDR_W-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic [ADDR_W-1:0]     top_base_ff, top_base_in;
   logic [ADDR_W-1:0]     last_base_ff, last_base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_ready;
   logic                  accept;
   logic [MROW_W-1:0]     mul_row;
   logic [PROD_W-1:0]     prod;
   logic [SADDR_W-1:0]    acol;
   logic [SADDR_W-1:0]    asum;
   logic [ADDR_W-1:0]     cell_addr;
   logic [SADDR_W-1:0]    next_top;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [CELL_W-1:0]     mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [CELL_W-1:0]     mem_rdata;

   tcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_ready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = req_ready;
   assign accept         = req_ch.valid && req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign mul_row = (state_ff == ST_IDLE && req_ch.payload.opcode == OP_READ)
                    ? MROW_W'(req_ch.payload.read_row) : MROW_W'(cur_row_ff);
   assign prod    = PROD_W'(mul_row) * PROD_W'(COLUMNS);
   assign off_in  = ADDR_W'(prod);

   assign acol      = (state_ff == ST_RADDR) ? SADDR_W'(rcol_ff) : SADDR_W'(cur_col_ff);
   assign asum      = SADDR_W'(off_ff) + acol + SADDR_W'(top_base_ff);
   assign cell_addr = (asum >= SADDR_W'(CELLS)) ? ADDR_W'(asum - SADDR_W'(CELLS))
                                                : ADDR_W'(asum);
   assign next_top  = SADDR_W'(top_base_ff) + SADDR_W'(COLUMNS);

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      scrolled_in  = scrolled_ff;
      code_in      = code_ff;
      rcol_in      = rcol_ff;
      rd_ok_in     = rd_ok_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      top_base_in  = top_base_ff;
      last_base_in = last_base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr;
      mem_wdata    = {code_ff, cfg.text_attribute};
      mem_re       = 1'b0;
      mem_raddr    = cell_addr;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {SPACE_CODE, RESET_ATTR};
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.payload.opcode == OP_READ) begin
                  rd_ok_in = (32'(req_ch.payload.read_row) < ROWS)
                             && (32'(req_ch.payload.read_col) < COLUMNS);
                  rcol_in  = req_ch.payload.read_col;
                  state_in = ST_RADDR;
               end else begin
                  code_in     = req_ch.payload.char_code;
                  scrolled_in = 1'b0;
                  if (32'(cur_row_ff) >= ROWS) begin
                     cur_row_in  = ROW_W'(ROWS - 1);
                     scrolled_in = 1'b1;
                     cnt_in      = '0;
                     after_in    = ST_HANDLE;
                     state_in    = ST_SCROLL;
                  end else begin
                     state_in = ST_HANDLE;
                  end
               end
            end
         end
         ST_RADDR: begin
            mem_re   = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_char  = rd_ok_ff ? mem_rdata[15:8] : 8'd0;
            rsp_data_in.cell_attr  = rd_ok_ff ? mem_rdata[7:0] : 8'd0;
            rsp_data_in.cursor_col = CURSOR_COL_W'(cur_col_ff);
            rsp_data_in.cursor_row = CURSOR_ROW_W'(cur_row_ff);
            rsp_data_in.did_scroll = 1'b0;
            state_in               = ST_IDLE;
         end
         ST_HANDLE: begin
            unique case (code_ff)
               CODE_TAB: begin
                  sum_in   = SUM_W'(cur_col_ff) + SUM_W'(cfg.tab_advance);
                  state_in = ST_TABDIV;
               end
               CODE_NEWLINE: begin
                  cur_col_in = '0;
                  if (32'(cur_row_ff) >= ROWS - 1) begin
                     scrolled_in = 1'b1;
                     cnt_in      = '0;
                     after_in    = ST_FINISH;
                     state_in    = ST_SCROLL;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                     state_in   = ST_FINISH;
                  end
               end
               CODE_RETURN: begin
                  cur_col_in = '0;
                  state_in   = ST_FINISH;
               end
               default: begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr;
                  mem_wdata = {code_ff, cfg.text_attribute};
                  if (32'(cur_col_ff) == COLUMNS - 1) begin
                     cur_col_in = '0;
                     cur_row_in = cur_row_ff + 1'b1;
                  end else begin
                     cur_col_in = cur_col_ff + 1'b1;
                  end
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_TABDIV: begin
            if (32'(sum_ff) >= COLUMNS) begin
               sum_in = sum_ff - SUM_W'(COLUMNS);
               if (32'(cur_row_ff) < ROWS) begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end else begin
               cur_col_in = COL_W'(sum_ff);
               if (32'(cur_row_ff) >= ROWS) begin
                  cur_row_in  = ROW_W'(ROWS - 1);
                  scrolled_in = 1'b1;
                  cnt_in      = '0;
                  after_in    = ST_FINISH;
                  state_in    = ST_SCROLL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCROLL: begin
            mem_re    = (32'(cnt_ff) < COLUMNS);
            mem_raddr = last_base_ff + cnt_ff;
            mem_we    = (cnt_ff != '0);
            mem_waddr = top_base_ff + cnt_ff - 1'b1;
            mem_wdata = {SPACE_CODE, mem_rdata[7:0]};
            if (cnt_ff == ADDR_W'(COLUMNS)) begin
               cnt_in       = '0;
               last_base_in = top_base_ff;
               top_base_in  = (next_top == SADDR_W'(CELLS)) ? '0 : ADDR_W'(next_top);
               state_in     = after_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.cell_char  = 8'd0;
            rsp_data_in.cell_attr  = 8'd0;
            rsp_data_in.cursor_col = CURSOR_COL_W'(cur_col_ff);
            rsp_data_in.cursor_row = CURSOR_ROW_W'(cur_row_ff);
            rsp_data_in.did_scroll = scrolled_ff;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         after_ff     <= ST_FINISH;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         scrolled_ff  <= 1'b0;
         cnt_ff       <= '0;
         top_base_ff  <= '0;
         last_base_ff <= ADDR_W'(CELLS - COLUMNS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         scrolled_ff  <= scrolled_in;
         cnt_ff       <= cnt_in;
         top_base_ff  <= top_base_in;
         last_base_ff <= last_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rcol_ff     <= rcol_in;
      rd_ok_ff    <= rd_ok_in;
      sum_ff      <= sum_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

   `TCW_ASSERT_IMPLIES(a_result_slot_free, state_ff == ST_READ || state_ff == ST_FINISH, !rsp_valid_ff)
   `TCW_ASSERT_IMPLIES(a_cursor_in_range, 1'b1, 32'(cur_col_ff) < COLUMNS && 32'(cur_row_ff) <= ROWS)
   `TCW_ASSERT_IMPLIES(a_handle_on_screen, state_ff == ST_HANDLE, 32'(cur_row_ff) < ROWS)
   `TCW_ASSERT_IMPLIES(a_scroll_rows_differ, state_ff == ST_SCROLL, top_base_ff != last_base_ff)
   `TCW_ASSERT_NEXT(a_scroll_moves_top, state_ff == ST_SCROLL && cnt_ff == ADDR_W'(COLUMNS), last_base_ff == $past(top_base_ff))
endmodule
